// ===== src/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared constants, register indexes and structs for the block sum pooler.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_DIM    = 64;
  localparam int DEF_ELEM_WIDTH = 16;

  // Fixed field widths
  localparam int DIM_W     = 7;   // matrix dimension and position counters
  localparam int SUM_W     = 28;  // block sum
  localparam int IDX_W     = 6;   // block row / block column on the output
  localparam int CFG_IDX_W = 8;   // register index on the config port
  localparam int DIM_RESET = 64;  // reset value of both dimension registers

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 8'd1;

  // Result queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = 2;

  // Effective dimensions and block size
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] bs;
  } dims_t;

  // One accepted element's place in the matrix
  typedef struct packed {
    logic             first;  // first element of its block
    logic             emit;   // last element of its block
    logic             last;   // last element of the matrix
    logic [DIM_W-1:0] bcol;
    logic [DIM_W-1:0] brow;
  } op_t;

  // One finished block
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [SUM_W-1:0] sum;
  } res_t;

endpackage

`default_nettype wire

// ===== src/bsp_cfg.sv =====
// ----------------------------------------------------------------------------
// bsp_cfg
// Dimension registers and an iterative subtractive GCD unit for the block size.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_cfg #(
  parameter int MAX_DIM = bsp_pkg::DEF_MAX_DIM
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr,
  input  wire logic [bsp_pkg::CFG_IDX_W-1:0] index,
  input  wire logic [bsp_pkg::DIM_W-1:0]     data,
  output      logic                          restart,
  output      logic                          busy,
  output      bsp_pkg::dims_t                dims
);

  localparam int MAX_EFF   = (MAX_DIM > 127) ? 127 : MAX_DIM;
  localparam int RESET_DIM = (bsp_pkg::DIM_RESET > MAX_EFF) ? MAX_EFF : bsp_pkg::DIM_RESET;
  localparam logic [bsp_pkg::DIM_W-1:0] MAX_EFF_V   = bsp_pkg::DIM_W'(MAX_EFF);
  localparam logic [bsp_pkg::DIM_W-1:0] RESET_DIM_V = bsp_pkg::DIM_W'(RESET_DIM);

  logic [bsp_pkg::DIM_W-1:0] rows;
  logic [bsp_pkg::DIM_W-1:0] cols;
  logic [bsp_pkg::DIM_W-1:0] bs;
  logic [bsp_pkg::DIM_W-1:0] ga;
  logic [bsp_pkg::DIM_W-1:0] gb;
  logic [bsp_pkg::DIM_W-1:0] eff;
  logic                      wr_rows;
  logic                      wr_cols;

  // Clamp a written dimension into 1..MAX_DIM, and never above 127
  always_comb begin
    if (data == '0) begin
      eff = bsp_pkg::DIM_W'(1);
    end else if (data > MAX_EFF_V) begin
      eff = MAX_EFF_V;
    end else begin
      eff = data;
    end
  end

  assign wr_rows = wr && (index == bsp_pkg::REG_NUM_ROWS);
  assign wr_cols = wr && (index == bsp_pkg::REG_NUM_COLS);
  assign restart = wr_rows || wr_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= RESET_DIM_V;
      cols <= RESET_DIM_V;
      bs   <= RESET_DIM_V;
      busy <= 1'b0;
    end else if (restart) begin
      if (wr_rows) begin
        rows <= eff;
      end
      if (wr_cols) begin
        cols <= eff;
      end
      busy <= 1'b1;
    end else if (busy) begin
      if (ga == gb) begin
        bs   <= ga;
        busy <= 1'b0;
      end
    end
  end

  // One subtraction a cycle until both operands agree
  always_ff @(posedge clk) begin
    if (restart) begin
      ga <= wr_rows ? eff : rows;
      gb <= wr_cols ? eff : cols;
    end else if (busy) begin
      if (ga > gb) begin
        ga <= ga - gb;
      end else if (gb > ga) begin
        gb <= gb - ga;
      end
    end
  end

  assign dims.rows = rows;
  assign dims.cols = cols;
  assign dims.bs   = bs;

endmodule

`default_nettype wire

// ===== src/bsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsp_ctrl
// Position counters: matrix row/column, place in block and block row/column.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           restart,
  input  wire logic           accept,
  input  wire bsp_pkg::dims_t dims,
  output      bsp_pkg::op_t   op
);

  logic [bsp_pkg::DIM_W-1:0] row_pos;
  logic [bsp_pkg::DIM_W-1:0] col_pos;
  logic [bsp_pkg::DIM_W-1:0] rib;
  logic [bsp_pkg::DIM_W-1:0] cib;
  logic [bsp_pkg::DIM_W-1:0] brow;
  logic [bsp_pkg::DIM_W-1:0] bcol;
  logic [bsp_pkg::DIM_W-1:0] bs_m1;
  logic                      col_end;
  logic                      row_end;
  logic                      cib_end;
  logic                      rib_end;

  assign bs_m1   = dims.bs - bsp_pkg::DIM_W'(1);
  assign col_end = (col_pos == dims.cols - bsp_pkg::DIM_W'(1));
  assign row_end = (row_pos == dims.rows - bsp_pkg::DIM_W'(1));
  assign cib_end = (cib == bs_m1);
  assign rib_end = (rib == bs_m1);

  assign op.first = (rib == '0) && (cib == '0);
  assign op.emit  = rib_end && cib_end;
  assign op.last  = row_end && col_end;
  assign op.bcol  = bcol;
  assign op.brow  = brow;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_pos <= '0;
      col_pos <= '0;
      rib     <= '0;
      cib     <= '0;
      brow    <= '0;
      bcol    <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_pos <= '0;
        cib     <= '0;
        bcol    <= '0;
        if (row_end) begin
          row_pos <= '0;
          rib     <= '0;
          brow    <= '0;
        end else begin
          row_pos <= row_pos + bsp_pkg::DIM_W'(1);
          rib     <= rib_end ? '0 : rib + bsp_pkg::DIM_W'(1);
          brow    <= rib_end ? brow + bsp_pkg::DIM_W'(1) : brow;
        end
      end else begin
        col_pos <= col_pos + bsp_pkg::DIM_W'(1);
        cib     <= cib_end ? '0 : cib + bsp_pkg::DIM_W'(1);
        bcol    <= cib_end ? bcol + bsp_pkg::DIM_W'(1) : bcol;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/bsp_accum.sv =====
// ----------------------------------------------------------------------------
// bsp_accum
// Column-sum memory with read-modify-write and a one-deep write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_accum #(
  parameter int MAX_DIM    = bsp_pkg::DEF_MAX_DIM,
  parameter int ELEM_WIDTH = bsp_pkg::DEF_ELEM_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [ELEM_WIDTH-1:0] element,
  input  wire bsp_pkg::op_t          op,
  output      logic                  res_valid,
  output      bsp_pkg::res_t         res
);

  localparam int MEM_DEPTH = (MAX_DIM > 128) ? 128 : MAX_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic [bsp_pkg::SUM_W-1:0] mem [MEM_DEPTH];

  logic [ADDR_W-1:0]                    rd_addr;
  logic [bsp_pkg::SUM_W-1:0]            rd_data;
  logic                                 s1_valid;
  bsp_pkg::op_t                         s1_op;
  logic [ADDR_W-1:0]                    s1_addr;
  logic [ELEM_WIDTH+bsp_pkg::SUM_W-1:0] s1_wide;
  logic [bsp_pkg::SUM_W-1:0]            s1_elem;
  logic [bsp_pkg::SUM_W-1:0]            base;
  logic [bsp_pkg::SUM_W-1:0]            sum;
  logic                                 fw_valid;
  logic [ADDR_W-1:0]                    fw_addr;
  logic [bsp_pkg::SUM_W-1:0]            fw_data;
  logic [ELEM_WIDTH-1:0]                s1_raw;

  assign rd_addr = op.bcol[ADDR_W-1:0];

  // Read on accept; data lands alongside the stage-1 registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[rd_addr];
    end
    if (s1_valid) begin
      mem[s1_addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      fw_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op;
      s1_addr <= rd_addr;
      s1_raw  <= element;
    end
    fw_addr <= s1_addr;
    fw_data <= sum;
  end

  // Sign-extend (or truncate) the element to the sum width
  assign s1_wide = {{bsp_pkg::SUM_W{s1_raw[ELEM_WIDTH-1]}}, s1_raw};
  assign s1_elem = s1_wide[bsp_pkg::SUM_W-1:0];

  // A write in the cycle of our read is not yet seen by the memory: take it here
  assign base = (fw_valid && (fw_addr == s1_addr)) ? fw_data : rd_data;
  assign sum  = s1_op.first ? s1_elem : base + s1_elem;

  assign res_valid = s1_valid && s1_op.emit;
  assign res.sum   = sum;
  assign res.row   = s1_op.brow[bsp_pkg::IDX_W-1:0];
  assign res.col   = s1_op.bcol[bsp_pkg::IDX_W-1:0];
  assign res.last  = s1_op.last;

endmodule

`default_nettype wire

// ===== src/bsp_outq.sv =====
// ----------------------------------------------------------------------------
// bsp_outq
// Small result queue between the accumulator and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_outq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire bsp_pkg::res_t              din,
  input  wire logic                       pop,
  output      logic                       not_empty,
  output      bsp_pkg::res_t              dout,
  output      logic [bsp_pkg::OQ_PTR_W-1:0] count
);

  localparam logic [bsp_pkg::OQ_PTR_W-1:0] LAST_SLOT = bsp_pkg::OQ_PTR_W'(bsp_pkg::OQ_DEPTH - 1);

  bsp_pkg::res_t                 slots [bsp_pkg::OQ_DEPTH];
  logic [bsp_pkg::OQ_PTR_W-1:0]  wr_ptr;
  logic [bsp_pkg::OQ_PTR_W-1:0]  rd_ptr;
  logic                          do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + bsp_pkg::OQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + bsp_pkg::OQ_PTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + bsp_pkg::OQ_PTR_W'(1);
        2'b01:   count <= count - bsp_pkg::OQ_PTR_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/block_sum_pooling_gcd.sv =====
// ----------------------------------------------------------------------------
// block_sum_pooling_gcd
// Non-overlapping square block sum pooling, block size gcd(rows, cols).
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ---------------------------------
//  s_axis    in         s_axis_tvalid/tready   tdata: element
//  m_axis    out        m_axis_tvalid/tready   tdata: block_sum, block_row,
//                                              block_col; tlast: last_block
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  One element a cycle while s_axis_tready is high. An element is read from
//  the column-sum memory on accept and written back in the cycle after; a
//  block sum goes through the stage-1 registers and the result queue to m_axis.
//  After a dimension write the block size is found by repeated subtraction,
//  one step a cycle; s_axis is held off meanwhile.
//  Reset restores 64 x 64 (clamped to MAX_DIM) with no clearing pass: every
//  block's first element loads its column sum.
//  A stalled m_axis backs up into a three-word result queue; s_axis drops
//  ready when that queue could overflow, as well as during the subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module block_sum_pooling_gcd #(
  parameter int MAX_DIM    = bsp_pkg::DEF_MAX_DIM,
  parameter int ELEM_WIDTH = bsp_pkg::DEF_ELEM_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // element
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [((ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // block_sum [27:0], block_row [33:28], block_col [39:34]
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [39:0]                   m_axis_tdata,
  output      logic                          m_axis_tlast,
  // configuration writes
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [bsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bsp_pkg::DIM_W-1:0]     cfg_data
);

  logic                           restart;
  logic                           gcd_busy;
  bsp_pkg::dims_t                 dims;
  logic                           accept;
  bsp_pkg::op_t                   op;
  logic                           res_valid;
  bsp_pkg::res_t                  res;
  bsp_pkg::res_t                  head;
  logic [bsp_pkg::OQ_PTR_W-1:0]   q_count;
  logic [bsp_pkg::OQ_PTR_W:0]     committed;

  // Always taken; the user must write only while the block is idle, unenforced
  assign cfg_ready = 1'b1;

  // Hold off new words while the queue plus the result in flight could fill it
  assign committed     = {1'b0, q_count} + {{bsp_pkg::OQ_PTR_W{1'b0}}, res_valid};
  assign s_axis_tready = !gcd_busy &&
                         (committed < (bsp_pkg::OQ_PTR_W+1)'(bsp_pkg::OQ_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  bsp_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr      (cfg_valid && cfg_ready),
    .index   (cfg_index),
    .data    (cfg_data),
    .restart (restart),
    .busy    (gcd_busy),
    .dims    (dims)
  );

  bsp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .accept  (accept),
    .dims    (dims),
    .op      (op)
  );

  bsp_accum #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .element   (s_axis_tdata[ELEM_WIDTH-1:0]),
    .op        (op),
    .res_valid (res_valid),
    .res       (res)
  );

  bsp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .pop       (m_axis_tready),
    .not_empty (m_axis_tvalid),
    .dout      (head),
    .count     (q_count)
  );

  assign m_axis_tdata = {head.col, head.row, head.sum};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ===== verif/bsp_block_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsp_block_checker
// Watches the element, block and configuration channels of the pooler,
// predicts every block sum from the accepted elements and compares it with
// the word that leaves the block.
// ----------------------------------------------------------------------------
module bsp_block_checker
  import bsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // element
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [39:0]          m_axis_tdata,   // block_sum, block_row, block_col
  input  logic                 m_axis_tlast,   // last_block
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   errors,
  output int                   blocks_due
);

  localparam int MAX_SIDE = DEF_MAX_DIM;

  logic [DIM_W-1:0]   rows_reg;
  logic [DIM_W-1:0]   cols_reg;
  int                 side;
  int                 row_at;
  int                 col_at;
  int                 row_in;
  int                 col_in;
  logic signed [28:0] col_sum [MAX_SIDE];
  res_t               due_blocks [$];

  // zero reads as one, anything past the array reads as full size
  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic int common_side(int a, int b);
    while (a != b) begin
      if (a > b) a -= b;
      else b -= a;
    end
    return a;
  endfunction

  function automatic void restart_matrix();
    side   = common_side(clamp_dim(rows_reg), clamp_dim(cols_reg));
    row_at = 0;
    col_at = 0;
    row_in = 0;
    col_in = 0;
  endfunction

  function automatic void predict_element(logic [15:0] raw);
    int   rows;
    int   cols;
    int   bc;
    res_t blk;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    bc   = col_at / side;
    if (bc > MAX_SIDE - 1) bc = MAX_SIDE - 1;
    // first element of a block loads the column sum, the rest add to it
    if (row_in == 0 && col_in == 0) begin
      col_sum[bc] = {{13{raw[15]}}, raw};
    end else begin
      col_sum[bc] = col_sum[bc] + {{13{raw[15]}}, raw};
    end
    if (row_in == side - 1 && col_in == side - 1) begin
      blk.sum  = col_sum[bc][SUM_W-1:0];
      blk.row  = IDX_W'(row_at / side);
      blk.col  = IDX_W'(bc);
      blk.last = (row_at == rows - 1) && (col_at == cols - 1);
      due_blocks.push_back(blk);
    end
    col_in++;
    if (col_in >= side) col_in = 0;
    col_at++;
    if (col_at >= cols) begin
      col_at = 0;
      col_in = 0;
      row_at++;
      row_in++;
      if (row_in >= side) row_in = 0;
      if (row_at >= rows) begin
        row_at = 0;
        row_in = 0;
      end
    end
  endfunction

  function automatic void flag_field(string field, int want_v, int got_v);
    errors++;
    $display("%0t  %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
  endfunction

  function automatic void check_block(res_t got);
    res_t want;
    if (due_blocks.size() == 0) begin
      errors++;
      $display("%0t  unexpected block word: expected none, actual sum %0d row %0d",
               $time, $signed(got.sum), got.row);
      $display("%0t  unexpected block word: actual col %0d last %0b",
               $time, got.col, got.last);
      return;
    end
    want = due_blocks.pop_front();
    if (got.sum != want.sum)
      flag_field("block_sum", int'($signed(want.sum)), int'($signed(got.sum)));
    if (got.row != want.row) flag_field("block_row", int'(want.row), int'(got.row));
    if (got.col != want.col) flag_field("block_col", int'(want.col), int'(got.col));
    if (got.last != want.last) flag_field("last_block", int'(want.last), int'(got.last));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rows_reg = DIM_W'(DIM_RESET);
      cols_reg = DIM_W'(DIM_RESET);
      restart_matrix();
      foreach (col_sum[i]) col_sum[i] = '0;
      due_blocks.delete();
    end else begin
      // unknown register indexes leave the matrix where it is
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NUM_ROWS) begin
          rows_reg = cfg_data;
          restart_matrix();
        end else if (cfg_index == REG_NUM_COLS) begin
          cols_reg = cfg_data;
          restart_matrix();
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_element(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_block({m_axis_tlast, m_axis_tdata});
    end
    blocks_due = due_blocks.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top level for the block sum pooler: drives element and configuration
// words with random idling, stalls the block stream, and reports the
// verdict from the checker's error and pending-block counts.
// ----------------------------------------------------------------------------
module tb;
  import bsp_pkg::*;

  localparam int ELEMENTS_WANTED = 1700;
  localparam int CALM_TAIL       = 250;   // last elements go with no idling
  localparam int LONG_HOLD       = 200;   // cycles of the long receiver stall
  localparam int DRAIN_CYCLES    = 8;     // lets the accumulator pipeline drain

  // register indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND = 8'hFF;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;   // element
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [39:0]          m_axis_tdata;   // block_sum [27:0], block_row [33:28], block_col [39:34]
  logic                 m_axis_tlast;   // last_block
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  int errors;
  int blocks_due;
  int sent;
  int cur_rows;   // raw register values, only used to size each phase
  int cur_cols;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  logic [15:0] corner_vals [6] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  block_sum_pooling_gcd dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bsp_block_checker block_watch (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .blocks_due    (blocks_due)
  );

  // Mostly random payload, with a fair share of the two extremes and of
  // small values around zero so that sums cancel and cross zero.
  function automatic logic [15:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Raw dimension values: zero, full size, past full size, or any legal size.
  function automatic logic [DIM_W-1:0] edge_dim();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return DIM_W'(DEF_MAX_DIM);
      2:       return DIM_W'($urandom_range(DEF_MAX_DIM + 1, 127));
      default: return DIM_W'($urandom_range(1, DEF_MAX_DIM));
    endcase
  endfunction

  function automatic int dim_used(int v);
    if (v == 0) return 1;
    if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
    return v;
  endfunction

  // Offer one configuration word and hold it until taken. Leave valid high:
  // the caller drops it once the last word of the group has gone.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_NUM_ROWS) cur_rows = int'(val);
    else if (idx == REG_NUM_COLS) cur_cols = int'(val);
  endtask

  // Offer one element word, perhaps after an idle burst, and hold it until
  // accepted. Valid stays high so back-to-back words need no extra step.
  task automatic send_element(logic [15:0] value);
    if (tx_idle_on && (sent < ELEMENTS_WANTED - CALM_TAIL) &&
        $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Drop the element stream, wait for every expected block to arrive, then
  // give the pipeline time to finish elements that close no block.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (blocks_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stall bursts, a long hold-off on request, else ready.
  initial begin : receiver
    bit hold_done;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle_on && (sent < ELEMENTS_WANTED - CALM_TAIL) &&
                   $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int n;
    int span;
    int b;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    hold_req      = 1'b0;
    cur_rows      = DIM_RESET;
    cur_cols      = DIM_RESET;
    sent          = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset shape is 64 x 64 with one 64-wide block: send two elements of its
    // first row only, then restart through the configuration.
    send_element(16'h7FFF);
    send_element(16'h8000);
    settle();

    // 1 x 1: every element is a block of its own and the last of its
    // matrix, so each one wraps straight into a new matrix.
    write_reg(REG_NUM_ROWS, DIM_W'(1));
    write_reg(REG_NUM_COLS, DIM_W'(1));
    cfg_valid <= 1'b0;
    foreach (corner_vals[i]) send_element(corner_vals[i]);
    settle();

    // 2 x 4: two blocks of side two, extremes mixed in each.
    write_reg(REG_NUM_ROWS, DIM_W'(2));
    write_reg(REG_NUM_COLS, DIM_W'(4));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 8; i++) send_element((i % 3 == 0) ? 16'h8000 : 16'h7FFF);

    // Write an unknown index part way into the next matrix: the block must
    // ignore it and carry on where it was.
    send_element(16'h1234);
    send_element(16'hFEDC);
    send_element(16'h0001);
    settle();
    write_reg(REG_BEYOND, DIM_W'(3));
    cfg_valid <= 1'b0;
    send_element(16'h7FFF);
    send_element(16'h0002);
    send_element(16'hFFFF);
    settle();

    // Zero rows reads as one, 127 columns as full width.
    write_reg(REG_NUM_ROWS, DIM_W'(0));
    write_reg(REG_NUM_COLS, DIM_W'(127));
    cfg_valid <= 1'b0;
    repeat (3) send_element(rand_element());
    settle();

    // 3 x 5 closes a block on every element; hold the receiver off for a
    // long stretch so the result queue fills and the input stalls.
    write_reg(REG_NUM_ROWS, DIM_W'(3));
    write_reg(REG_NUM_COLS, DIM_W'(5));
    cfg_valid <= 1'b0;
    hold_req = 1'b1;
    repeat (60) send_element(rand_element());

    // Random phases, each with its own shape and idling mix.
    while (sent < ELEMENTS_WANTED) begin
      settle();
      tx_idle_on = (sent < ELEMENTS_WANTED - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (sent < ELEMENTS_WANTED - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          write_reg(REG_NUM_ROWS, edge_dim());
          write_reg(REG_NUM_COLS, edge_dim());
        end
        1: write_reg($urandom_range(0, 1) ? REG_NUM_ROWS : REG_NUM_COLS,
                     DIM_W'($urandom_range(1, 16)));
        2: write_reg(CFG_IDX_W'($urandom_range(REG_NUM_COLS + 1, 255)),
                     DIM_W'($urandom_range(0, 127)));
        default: begin
          // shared factor so the block side is often above one
          b = $urandom_range(1, 4);
          if ($urandom_range(0, 1)) begin
            write_reg(REG_NUM_ROWS, DIM_W'(b * $urandom_range(1, 4)));
            write_reg(REG_NUM_COLS, DIM_W'(b * $urandom_range(1, 4)));
          end else begin
            write_reg(REG_NUM_COLS, DIM_W'(b * $urandom_range(1, 4)));
            write_reg(REG_NUM_ROWS, DIM_W'(b * $urandom_range(1, 4)));
          end
        end
      endcase
      cfg_valid <= 1'b0;

      // Whole matrices where they are small, a slice of the big ones, and
      // now and then a partial tail that the next write cuts off.
      span = dim_used(cur_rows) * dim_used(cur_cols);
      if (span <= 64) n = span * $urandom_range(1, 3);
      else if (span <= 300) n = span;
      else n = $urandom_range(20, 150);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 20);
      repeat (n) send_element(rand_element());
    end

    settle();
    @(negedge clk);
    if (errors == 0 && blocks_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
